>>> design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// holds whenever out of reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/lcm_pkg.sv
`timescale 1ns / 1ps
package lcm_pkg;
	localparam int OP_W = 4;
	localparam int PID_W = 5;
	localparam int IDX_W = 4;
	localparam int ST_W = 3;

	localparam logic [OP_W-1:0] OP_LOCK_INIT = 4'd0;
	localparam logic [OP_W-1:0] OP_ACQUIRE   = 4'd1;
	localparam logic [OP_W-1:0] OP_RELEASE   = 4'd2;
	localparam logic [OP_W-1:0] OP_CVAR_INIT = 4'd3;
	localparam logic [OP_W-1:0] OP_WAIT      = 4'd4;
	localparam logic [OP_W-1:0] OP_SIGNAL    = 4'd5;
	localparam logic [OP_W-1:0] OP_BCAST     = 4'd6;
	localparam logic [OP_W-1:0] OP_RECL_LOCK = 4'd7;
	localparam logic [OP_W-1:0] OP_RECL_CVAR = 4'd8;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_SLOT  = 3'd1;
	localparam logic [ST_W-1:0] ST_INACTIVE = 3'd2;
	localparam logic [ST_W-1:0] ST_NOT_OWN  = 3'd3;
	localparam logic [ST_W-1:0] ST_BUSY     = 3'd4;

	localparam int BCAST_MAX = 32;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT,
		S_BCAST
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture request
		logic exec;   // evaluate and update tables
		logic bstep;  // pop one broadcast waiter
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bcast_more;  // broadcast needs another beat
	} stat_t;
endpackage

>>> design/lcm_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcm_ctrl
	import lcm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  out_fire,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  in_rdy,
	output logic  out_vld
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_rdy = 1'b1;
				cmd.load = in_fire;
				if (in_fire) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_vld = 1'b1;
				if (out_fire) begin
					if (stat.bcast_more) state_d = S_BCAST;
					else state_d = S_IDLE;
				end
			end
			S_BCAST: begin
				cmd.bstep = 1'b1;
				state_d = S_OUT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	`ASSERT_NEXT(a_load_exec, clk, arst_n, cmd.load, state_q == S_EXEC, "load not followed by exec")
	`ASSERT_ALWAYS(a_one_cmd, clk, arst_n, $onehot0(cmd), "several commands at once")
	`ASSERT_NEXT(a_exec_out, clk, arst_n, cmd.exec, out_vld, "exec not followed by result")
endmodule

>>> design/lcm_dp.sv
`timescale 1ns / 1ps
module lcm_dp
	import lcm_pkg::*;
#(
	parameter int LOCK_SLOTS = 16,
	parameter int CVAR_SLOTS = 16,
	parameter int PROCESSES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [OP_W-1:0]  op,
	input  logic [PID_W-1:0] pid,
	input  logic [IDX_W-1:0] lk_sel,
	input  logic [IDX_W-1:0] cv_sel,
	output stat_t            stat,
	output logic [ST_W-1:0]  status,
	output logic             granted,
	output logic [IDX_W-1:0] new_index,
	output logic             woken_valid,
	output logic [PID_W-1:0] woken_pid,
	output logic             last
);
	localparam int LW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
	localparam int CW = (CVAR_SLOTS > 1) ? $clog2(CVAR_SLOTS) : 1;
	localparam int PW = $clog2(PROCESSES);
	localparam int NW = $clog2(PROCESSES + 1);

	logic [LOCK_SLOTS-1:0] lact_q, lheld_q;
	logic [PW-1:0] lown_q [LOCK_SLOTS];
	logic [PW-1:0] lhead_q [LOCK_SLOTS];
	logic [PW-1:0] ltail_q [LOCK_SLOTS];
	logic [NW-1:0] lcnt_q [LOCK_SLOTS];
	logic [CVAR_SLOTS-1:0] cact_q;
	logic [PW-1:0] chead_q [CVAR_SLOTS];
	logic [PW-1:0] ctail_q [CVAR_SLOTS];
	logic [NW-1:0] ccnt_q [CVAR_SLOTS];
	logic [PW-1:0] nxt_q [PROCESSES];

	logic [OP_W-1:0] op_q;
	logic [PID_W-1:0] pid_q;
	logic [IDX_W-1:0] li_q, ci_q;
	logic [5:0] bk_q;
	logic bmore_q;

	logic [LW-1:0] l;
	logic [CW-1:0] c;
	logic lok, cok, pok, l_inr, c_inr;
	logic [PW-1:0] p;
	logic [PW-1:0] lhd, ctl, chd;
	logic [NW-1:0] lc, cc;
	logic own;
	logic lfree, cfree;
	logic [LW-1:0] lfi;
	logic [CW-1:0] cfi;

	assign l = LW'(li_q);
	assign c = CW'(ci_q);
	assign p = PW'(pid_q);
	assign l_inr = {{(32-IDX_W){1'b0}}, li_q} < LOCK_SLOTS;
	assign c_inr = {{(32-IDX_W){1'b0}}, ci_q} < CVAR_SLOTS;
	assign lok = l_inr && lact_q[l];
	assign cok = c_inr && cact_q[c];
	assign pok = {{(32-PID_W){1'b0}}, pid_q} < PROCESSES;
	assign lhd = lhead_q[l];
	assign lc = lcnt_q[l];
	assign chd = chead_q[c];
	assign ctl = ctail_q[c];
	assign cc = ccnt_q[c];
	assign own = lheld_q[l] && ({{(32-PW){1'b0}}, lown_q[l]} == {{(32-PID_W){1'b0}}, pid_q});

	// priority search for lowest free slot
	always_comb begin
		lfree = 1'b0;
		lfi = '0;
		for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
			if (!lact_q[i]) begin
				lfree = 1'b1;
				lfi = LW'(i);
			end
		end
		cfree = 1'b0;
		cfi = '0;
		for (int i = CVAR_SLOTS - 1; i >= 0; i--) begin
			if (!cact_q[i]) begin
				cfree = 1'b1;
				cfi = CW'(i);
			end
		end
	end

	assign stat.bcast_more = bmore_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lact_q <= '0;
			lheld_q <= '0;
			cact_q <= '0;
			bmore_q <= 1'b0;
			for (int i = 0; i < LOCK_SLOTS; i++) lcnt_q[i] <= '0;
			for (int i = 0; i < CVAR_SLOTS; i++) ccnt_q[i] <= '0;
		end else if (cmd.exec) begin
			bmore_q <= 1'b0;
			case (op_q)
				OP_LOCK_INIT: if (lfree) begin
					lact_q[lfi] <= 1'b1;
					lheld_q[lfi] <= 1'b0;
					lown_q[lfi] <= '0;
					lcnt_q[lfi] <= '0;
				end
				OP_ACQUIRE: if (lok && pok) begin
					if (!lheld_q[l]) begin
						lheld_q[l] <= 1'b1;
						lown_q[l] <= p;
					end else if ({{(32-NW){1'b0}}, lc} < PROCESSES) begin
						if (lc == '0) lhead_q[l] <= p;
						else nxt_q[ltail_q[l]] <= p;
						ltail_q[l] <= p;
						lcnt_q[l] <= lc + NW'(1);
					end
				end
				OP_RELEASE, OP_WAIT: begin
					if (lok && pok && own && (op_q == OP_RELEASE ||
					    (cok && {{(32-NW){1'b0}}, cc} < PROCESSES))) begin
						if (op_q == OP_WAIT) begin
							if (cc == '0) chead_q[c] <= p;
							else nxt_q[ctl] <= p;
							ctail_q[c] <= p;
							ccnt_q[c] <= cc + NW'(1);
						end
						if (lc != '0) begin
							lown_q[l] <= lhd;
							// the handoff follows the link that the wait just wrote
							if (op_q == OP_WAIT && cc != '0 && ctl == lhd) lhead_q[l] <= p;
							else lhead_q[l] <= nxt_q[lhd];
							lcnt_q[l] <= lc - NW'(1);
						end else begin
							lheld_q[l] <= 1'b0;
							lown_q[l] <= '0;
						end
					end
				end
				OP_CVAR_INIT: if (cfree) begin
					cact_q[cfi] <= 1'b1;
					ccnt_q[cfi] <= '0;
				end
				OP_SIGNAL, OP_BCAST: if (cok && cc != '0) begin
					chead_q[c] <= nxt_q[chd];
					ccnt_q[c] <= cc - NW'(1);
					bmore_q <= (op_q == OP_BCAST) && (cc != NW'(1));
				end
				OP_RECL_LOCK: if (lok && !lheld_q[l] && lc == '0) lact_q[l] <= 1'b0;
				OP_RECL_CVAR: if (cok && cc == '0) cact_q[c] <= 1'b0;
				default: ;
			endcase
		end else if (cmd.bstep) begin
			chead_q[c] <= nxt_q[chd];
			ccnt_q[c] <= cc - NW'(1);
			bmore_q <= (cc != NW'(1)) && (bk_q != 6'(BCAST_MAX - 2));
		end
	end

	// request capture and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			pid_q <= pid;
			li_q <= lk_sel;
			ci_q <= cv_sel;
		end
		if (cmd.exec) begin
			status <= ST_OK;
			granted <= 1'b0;
			new_index <= '0;
			woken_valid <= 1'b0;
			woken_pid <= '0;
			last <= 1'b1;
			bk_q <= '0;
			case (op_q)
				OP_LOCK_INIT: begin
					if (lfree) new_index <= IDX_W'(lfi);
					else status <= ST_NO_SLOT;
				end
				OP_ACQUIRE: begin
					if (!lok || !pok) status <= ST_INACTIVE;
					else if (!lheld_q[l]) granted <= 1'b1;
					else if ({{(32-NW){1'b0}}, lc} >= PROCESSES) status <= ST_BUSY;
				end
				OP_RELEASE: begin
					if (!lok || !pok) status <= ST_INACTIVE;
					else if (!own) status <= ST_NOT_OWN;
					else if (lc != '0) begin
						woken_valid <= 1'b1;
						woken_pid <= PID_W'(lhd);
					end
				end
				OP_CVAR_INIT: begin
					if (cfree) new_index <= IDX_W'(cfi);
					else status <= ST_NO_SLOT;
				end
				OP_WAIT: begin
					if (!cok || !lok || !pok) status <= ST_INACTIVE;
					else if (!own) status <= ST_NOT_OWN;
					else if ({{(32-NW){1'b0}}, cc} >= PROCESSES) status <= ST_BUSY;
					else if (lc != '0) begin
						woken_valid <= 1'b1;
						woken_pid <= PID_W'(lhd);
					end
				end
				OP_SIGNAL, OP_BCAST: begin
					if (!cok) status <= ST_INACTIVE;
					else if (cc != '0) begin
						woken_valid <= 1'b1;
						woken_pid <= PID_W'(chd);
						last <= !((op_q == OP_BCAST) && (cc != NW'(1)));
					end
				end
				OP_RECL_LOCK: begin
					if (!lok) status <= ST_INACTIVE;
					else if (lheld_q[l] || lc != '0) status <= ST_BUSY;
				end
				OP_RECL_CVAR: begin
					if (!cok) status <= ST_INACTIVE;
					else if (cc != '0) status <= ST_BUSY;
				end
				default: status <= ST_INACTIVE;
			endcase
		end else if (cmd.bstep) begin
			woken_pid <= PID_W'(chd);
			last <= (cc == NW'(1)) || (bk_q == 6'(BCAST_MAX - 2));
			bk_q <= bk_q + 6'd1;
		end
	end
endmodule

>>> design/lock_and_condvar_manager_top.sv
`timescale 1ns / 1ps
// channel  dir  tdata (lsb first)                                   tlast
// s_axis   in   op[3:0] pid[8:4] lk_sel[12:9] cv_sel[16:13]          -
// m_axis   out  status[2:0] granted[3] new_index[7:4]                last
//               woken_valid[8] woken_pid[13:9]
// one request at a time: capture, table update, then the result beat
// a broadcast adds a result beat per extra waiter, up to BCAST_MAX beats in all
// the controller state sequence in lcm_ctrl sets the pace of requests
// arst_n clears active bits and waiter counts; no clearing pass
// a stalled m_axis holds the beat and keeps s_axis_tready low
module lock_and_condvar_manager_top
	import lcm_pkg::*;
#(
	parameter int LOCK_SLOTS = 16,
	parameter int CVAR_SLOTS = 16,
	parameter int PROCESSES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op, pid, lk_sel, cv_sel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // status, granted, new_index, woken_valid, woken_pid
	output logic        m_axis_tlast
);
	cmd_t cmd;
	stat_t stat;
	logic [ST_W-1:0] status;
	logic granted, woken_valid;
	logic [IDX_W-1:0] new_index;
	logic [PID_W-1:0] woken_pid;

	lcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.stat(stat), .cmd(cmd),
		.in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
	);

	lcm_dp #(.LOCK_SLOTS(LOCK_SLOTS), .CVAR_SLOTS(CVAR_SLOTS), .PROCESSES(PROCESSES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.op(s_axis_tdata[3:0]), .pid(s_axis_tdata[8:4]),
		.lk_sel(s_axis_tdata[12:9]), .cv_sel(s_axis_tdata[16:13]),
		.stat(stat), .status(status), .granted(granted), .new_index(new_index),
		.woken_valid(woken_valid), .woken_pid(woken_pid), .last(m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, woken_pid, woken_valid, new_index, granted, status};
endmodule
